// File: rtl/core/cial_pkg.sv
// Shared types and codes for the checked integer ALU.
`default_nettype none
package cial_pkg;

   localparam int OPW   = 64;        // operand width
   localparam int DIV_N = OPW;       // divider stages, one quotient bit each
   localparam int SIDE_N = DIV_N + 1; // side line depth from the operand prep stage to the last div stage

   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_SUB = 4'd1;
   localparam logic [3:0] FUNC_MUL = 4'd2;
   localparam logic [3:0] FUNC_DIV = 4'd3;
   localparam logic [3:0] FUNC_MOD = 4'd4;
   localparam logic [3:0] FUNC_OR  = 4'd5;
   localparam logic [3:0] FUNC_AND = 4'd6;
   localparam logic [3:0] FUNC_XOR = 4'd7;
   localparam logic [3:0] FUNC_NOT = 4'd8;
   localparam logic [3:0] FUNC_NEG = 4'd9;

   localparam logic [1:0] ERR_OK   = 2'd0;
   localparam logic [1:0] ERR_OVF  = 2'd1;
   localparam logic [1:0] ERR_DIVZ = 2'd2;

   localparam logic [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};

   typedef struct packed {
      logic [3:0]            func;
      logic signed [OPW-1:0] operand_a;
      logic signed [OPW-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [OPW-1:0] result;
      logic [1:0]            error;
   } rsp_type;

   // per-word bookkeeping that rides beside the divider
   typedef struct packed {
      logic           valid;
      logic [3:0]     func;
      logic [OPW-1:0] res;
      logic [1:0]     err;
      logic           neg_prod;
      logic           neg_a;
   } side_type;

endpackage
`default_nettype wire

// File: rtl/core/cial_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module cial_div
   import cial_pkg::*;
(
   input  wire logic           clock,
   input  wire logic [OPW-1:0] num,
   input  wire logic [OPW-1:0] den,
   output logic      [OPW-1:0] quo,
   output logic      [OPW-1:0] rem
);

   logic [OPW-1:0] rem_ff [DIV_N];
   logic [OPW-1:0] quo_ff [DIV_N];
   logic [OPW-1:0] den_ff [DIV_N];
   logic [OPW-1:0] rem_in [DIV_N];
   logic [OPW-1:0] quo_in [DIV_N];
   logic [OPW-1:0] den_in [DIV_N];

   // one shift-compare-subtract per stage
   always_comb begin
      logic [OPW-1:0] rp, qp, dp, sh;
      logic           ge;
      for (int k = 0; k < DIV_N; k++) begin
         if (k == 0) begin
            rp = '0;
            qp = num;
            dp = den;
         end else begin
            rp = rem_ff[k-1];
            qp = quo_ff[k-1];
            dp = den_ff[k-1];
         end
         sh = {rp[OPW-2:0], qp[OPW-1]};
         ge = (sh >= dp);
         rem_in[k] = ge ? (sh - dp) : sh;
         quo_in[k] = {qp[OPW-2:0], ge};
         den_in[k] = dp;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_N; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_in[k];
      end
   end

   assign quo = quo_ff[DIV_N-1];
   assign rem = rem_ff[DIV_N-1];

endmodule
`default_nettype wire

// File: rtl/core/checked_integer_alu_unit.sv
// Top level of the checked 64-bit signed integer ALU.
//
// Usage: drive req_data and raise start; the word is taken at any clock
// edge where start is high and busy is low. busy is never raised, so one
// word may enter every cycle.
// Each word gives exactly one result word on rsp_data, marked by a one-cycle
// rsp_strobe, in input order. The input register loads at the accepting
// edge; the operand prep stage, the 64-stage divider (one quotient bit per
// stage) and the output register follow, and every operation passes
// through all of them on its way to rsp_strobe. Multiply uses four 32x32
// partial products, registered and then summed into a registered product
// that is range-checked as it enters the side line; short operations wait
// beside the divider.
// Throughput is one word per cycle.
// Errors: 1 on signed overflow (add, sub, mul, negate of most negative,
// most negative divided by minus one), 2 on divide or remainder by zero;
// result is zero whenever error is nonzero.
// Reset clears all valid bits; words in flight are dropped.
// The receiver cannot stall, so results are never held back.
`default_nettype none
module checked_integer_alu_unit
   import cial_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int HW = OPW / 2;

   logic           in_valid_ff;
   req_type        req_ff;
   side_type       side_ff [SIDE_N];
   side_type       side_in [SIDE_N];
   logic [OPW-1:0] ma_ff, mb_ff;
   logic [OPW-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [2*OPW-1:0] prod_ff;
   logic [OPW-1:0] quo, rem;
   logic           out_valid_ff;
   rsp_type        out_ff, out_in;
   side_type       head;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // short operations and special-case errors
   always_comb begin
      logic [OPW-1:0] a, b, s, d;
      a = req_ff.operand_a;
      b = req_ff.operand_b;
      s = a + b;
      d = a - b;
      head          = '0;
      head.valid    = in_valid_ff;
      head.func     = req_ff.func;
      head.neg_prod = a[OPW-1] ^ b[OPW-1];
      head.neg_a    = a[OPW-1];
      case (req_ff.func)
         FUNC_ADD: begin
            head.res = s;
            if (((a ^ s) & (b ^ s)) >> (OPW-1) != '0) head.err = ERR_OVF;
         end
         FUNC_SUB: begin
            head.res = d;
            if (((a ^ b) & (a ^ d)) >> (OPW-1) != '0) head.err = ERR_OVF;
         end
         FUNC_DIV, FUNC_MOD: begin
            if (b == '0) head.err = ERR_DIVZ;
            else if (req_ff.func == FUNC_DIV && a == MOST_NEG && b == '1)
               head.err = ERR_OVF;
         end
         FUNC_OR:  head.res = a | b;
         FUNC_AND: head.res = a & b;
         FUNC_XOR: head.res = a ^ b;
         FUNC_NOT: head.res = ~a;
         FUNC_NEG: begin
            if (a == MOST_NEG) head.err = ERR_OVF;
            else head.res = '0 - a;
         end
         default: head.res = '0;
      endcase
   end

   // operand magnitudes
   always_ff @(posedge clock) begin
      ma_ff <= req_ff.operand_a[OPW-1] ? ('0 - req_ff.operand_a) : req_ff.operand_a;
      mb_ff <= req_ff.operand_b[OPW-1] ? ('0 - req_ff.operand_b) : req_ff.operand_b;
   end

   // multiplier: partial products, then sum
   always_ff @(posedge clock) begin
      pp_ll_ff <= OPW'(ma_ff[HW-1:0])   * OPW'(mb_ff[HW-1:0]);
      pp_lh_ff <= OPW'(ma_ff[HW-1:0])   * OPW'(mb_ff[OPW-1:HW]);
      pp_hl_ff <= OPW'(ma_ff[OPW-1:HW]) * OPW'(mb_ff[HW-1:0]);
      pp_hh_ff <= OPW'(ma_ff[OPW-1:HW]) * OPW'(mb_ff[OPW-1:HW]);
      prod_ff  <= {{OPW{1'b0}}, pp_ll_ff}
                + ({{OPW{1'b0}}, pp_lh_ff} << HW)
                + ({{OPW{1'b0}}, pp_hl_ff} << HW)
                + {pp_hh_ff, {OPW{1'b0}}};
   end

   cial_div u_div (
      .clock (clock),
      .num   (ma_ff),
      .den   (mb_ff),
      .quo   (quo),
      .rem   (rem)
   );

   // side line; multiply result drops in once the product is ready
   always_comb begin
      logic [OPW-1:0] lo, hi;
      lo = prod_ff[OPW-1:0];
      hi = prod_ff[2*OPW-1:OPW];
      for (int k = 0; k < SIDE_N; k++) begin
         side_in[k] = (k == 0) ? head : side_ff[(k == 0) ? 0 : k-1];
         if (k == 3 && side_ff[2].func == FUNC_MUL) begin
            if (hi != '0 || lo > (side_ff[2].neg_prod ? MOST_NEG : MOST_NEG - 1'b1)) begin
               side_in[k].err = ERR_OVF;
               side_in[k].res = '0;
            end else begin
               side_in[k].res = side_ff[2].neg_prod ? ('0 - lo) : lo;
            end
         end
      end
   end

   // side line registers; only the valid bits see reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < SIDE_N; k++) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else begin
            side_ff[k].valid <= side_in[k].valid;
         end
         side_ff[k].func     <= side_in[k].func;
         side_ff[k].res      <= side_in[k].res;
         side_ff[k].err      <= side_in[k].err;
         side_ff[k].neg_prod <= side_in[k].neg_prod;
         side_ff[k].neg_a    <= side_in[k].neg_a;
      end
   end

   // output select and sign fix
   always_comb begin
      side_type t;
      t = side_ff[SIDE_N-1];
      out_in.error  = t.err;
      out_in.result = t.res;
      if (t.err != ERR_OK) begin
         out_in.result = '0;
      end else if (t.func == FUNC_DIV) begin
         out_in.result = t.neg_prod ? ('0 - quo) : quo;
      end else if (t.func == FUNC_MOD) begin
         out_in.result = t.neg_a ? ('0 - rem) : rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= side_ff[SIDE_N-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

   // checks
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.error != 2'd3))
      else $error("undefined error code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.error != ERR_OK) |-> (rsp_data.result == '0))
      else $error("nonzero result with error");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("strobe right after reset");

   a_divz: assert property (@(posedge clock) disable iff (reset)
      (head.valid && (head.func == FUNC_DIV || head.func == FUNC_MOD)
       && req_ff.operand_b == '0) |=> (side_ff[0].err == ERR_DIVZ))
      else $error("zero divisor not flagged");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the checked 64-bit signed integer ALU.
`default_nettype none
module testbench;
   import cial_pkg::*;

   localparam int GAP_MAX    = 19;
   localparam int RAND_WORDS = 430;
   localparam int DRAIN_CYC  = 80;
   localparam int STALL_MAX  = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   checked_integer_alu_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rsp_type alu_expected[$];
   int      mismatch_cnt;
   int      stall_cnt;

   // directed table; has_exp marks rows with a hand-typed answer
   typedef struct {
      logic [3:0]     func;
      logic [OPW-1:0] a;
      logic [OPW-1:0] b;
      bit             has_exp;
      logic [OPW-1:0] res;
      logic [1:0]     err;
   } dir_row_type;

   localparam logic [OPW-1:0] MAX_POS = {1'b0, {(OPW-1){1'b1}}};
   localparam logic [OPW-1:0] ALL_ONE = '1;

   dir_row_type dir_tab[] = '{
      '{FUNC_ADD, MAX_POS, 64'd1,    1, 64'd0, ERR_OVF},
      '{FUNC_ADD, MOST_NEG, ALL_ONE, 1, 64'd0, ERR_OVF},
      '{FUNC_ADD, 64'd5, ALL_ONE,    1, 64'd4, ERR_OK},
      '{FUNC_SUB, MOST_NEG, 64'd1,   1, 64'd0, ERR_OVF},
      '{FUNC_SUB, 64'd0, MOST_NEG,   1, 64'd0, ERR_OVF},
      '{FUNC_SUB, 64'd3, 64'd7,      0, 64'd0, ERR_OK},
      '{FUNC_MUL, MOST_NEG, 64'd1,   1, MOST_NEG, ERR_OK},
      '{FUNC_MUL, MOST_NEG, ALL_ONE, 1, 64'd0, ERR_OVF},
      '{FUNC_MUL, MAX_POS, MAX_POS,  1, 64'd0, ERR_OVF},
      '{FUNC_MUL, 64'h1_0000_0000, 64'h8000_0000, 1, 64'd0, ERR_OVF},
      '{FUNC_MUL, 64'h1_0000_0000, 64'hFFFF_FFFF_8000_0000, 1, MOST_NEG, ERR_OK},
      '{FUNC_DIV, 64'd7, 64'd0,      1, 64'd0, ERR_DIVZ},
      '{FUNC_MOD, 64'd7, 64'd0,      1, 64'd0, ERR_DIVZ},
      '{FUNC_DIV, MOST_NEG, ALL_ONE, 1, 64'd0, ERR_OVF},
      '{FUNC_MOD, MOST_NEG, ALL_ONE, 1, 64'd0, ERR_OK},
      '{FUNC_DIV, -64'sd7, 64'd2,    1, -64'sd3, ERR_OK},
      '{FUNC_MOD, -64'sd7, 64'd2,    1, -64'sd1, ERR_OK},
      '{FUNC_DIV, MAX_POS, MOST_NEG, 0, 64'd0, ERR_OK},
      '{FUNC_OR,  ALL_ONE, 64'd0,    1, ALL_ONE, ERR_OK},
      '{FUNC_AND, ALL_ONE, MOST_NEG, 1, MOST_NEG, ERR_OK},
      '{FUNC_XOR, ALL_ONE, MAX_POS,  1, MOST_NEG, ERR_OK},
      '{FUNC_NOT, 64'd0, ALL_ONE,    1, ALL_ONE, ERR_OK},
      '{FUNC_NEG, MOST_NEG, 64'd0,   1, 64'd0, ERR_OVF},
      '{FUNC_NEG, MAX_POS, 64'd0,    1, MOST_NEG + 64'd1, ERR_OK},
      '{4'd15, ALL_ONE, ALL_ONE,     1, 64'd0, ERR_OK}
   };

   function automatic logic [OPW-1:0] abs_val(logic [OPW-1:0] v);
      return v[OPW-1] ? -v : v;
   endfunction

   // golden ALU behavior
   function automatic rsp_type alu_predict(req_type w);
      logic [OPW-1:0]   a;
      logic [OPW-1:0]   b;
      logic [OPW-1:0]   r;
      logic [1:0]       e;
      logic [2*OPW-1:0] prod;
      logic             neg;
      rsp_type          o;
      a = w.operand_a;
      b = w.operand_b;
      r = '0;
      e = ERR_OK;
      neg = a[OPW-1] ^ b[OPW-1];
      case (w.func)
         FUNC_ADD: begin
            r = a + b;
            if ((a[OPW-1] ^ r[OPW-1]) & (b[OPW-1] ^ r[OPW-1])) e = ERR_OVF;
         end
         FUNC_SUB: begin
            r = a - b;
            if ((a[OPW-1] ^ b[OPW-1]) & (a[OPW-1] ^ r[OPW-1])) e = ERR_OVF;
         end
         FUNC_MUL: begin
            prod = {{OPW{1'b0}}, abs_val(a)} * {{OPW{1'b0}}, abs_val(b)};
            if (prod[2*OPW-1:OPW] != '0 ||
                prod[OPW-1:0] > (neg ? MOST_NEG : MOST_NEG - 1)) e = ERR_OVF;
            else r = neg ? -prod[OPW-1:0] : prod[OPW-1:0];
         end
         FUNC_DIV, FUNC_MOD: begin
            if (b == '0) e = ERR_DIVZ;
            else if (w.func == FUNC_DIV && a == MOST_NEG && b == '1) e = ERR_OVF;
            else if (w.func == FUNC_DIV) begin
               r = abs_val(a) / abs_val(b);
               if (neg) r = -r;
            end else begin
               r = abs_val(a) % abs_val(b);
               if (a[OPW-1]) r = -r;
            end
         end
         FUNC_OR:  r = a | b;
         FUNC_AND: r = a & b;
         FUNC_XOR: r = a ^ b;
         FUNC_NOT: r = ~a;
         FUNC_NEG: begin
            if (a == MOST_NEG) e = ERR_OVF;
            else r = -a;
         end
         default: r = '0;
      endcase
      if (e != ERR_OK) r = '0;
      o.result = r;
      o.error  = e;
      return o;
   endfunction

   // operand with bias toward edge values and small magnitudes
   function automatic logic [OPW-1:0] rand_operand();
      logic [OPW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = MOST_NEG;
         1: v = MAX_POS;
         2: v = ALL_ONE;
         3: v = '0;
         4: v = OPW'($signed(32'($urandom_range(0, 40)) - 32'd20));
         5: v = {{33{v[31]}}, v[30:0]};
         default: ;
      endcase
      return v;
   endfunction

   // send one word; start stays high between words sent back to back
   task automatic send_word(req_type w, bit has_exp, rsp_type exp_w, bit burst);
      int gap;
      gap = $urandom_range(0, GAP_MAX);
      if (burst || $urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      alu_expected.push_back(has_exp ? exp_w : alu_predict(w));
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset) begin
         if (rsp_strobe || (start && !busy)) stall_cnt <= 0;
         else stall_cnt <= stall_cnt + 1;
         if (rsp_strobe) begin
            if (alu_expected.size() == 0) begin
               mismatch_cnt <= mismatch_cnt + 1;
               if (mismatch_cnt < 10)
                  $display("unexpected word: result=%h error=%0d",
                           rsp_data.result, rsp_data.error);
            end else begin
               exp_w = alu_expected.pop_front();
               if (exp_w.result !== rsp_data.result || exp_w.error !== rsp_data.error) begin
                  mismatch_cnt <= mismatch_cnt + 1;
                  if (mismatch_cnt < 10)
                     $display("mismatch: exp result=%h error=%0d, got result=%h error=%0d",
                              exp_w.result, exp_w.error, rsp_data.result, rsp_data.error);
               end
            end
         end
         if (stall_cnt >= STALL_MAX) begin
            $display("FAIL checked_integer_alu_unit");
            $finish;
         end
      end
   end

   initial begin
      req_type w;
      rsp_type e;
      clock = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      mismatch_cnt = 0;
      stall_cnt = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (dir_tab[i]) begin
         w.func = dir_tab[i].func;
         w.operand_a = dir_tab[i].a;
         w.operand_b = dir_tab[i].b;
         e.result = dir_tab[i].res;
         e.error  = dir_tab[i].err;
         send_word(w, dir_tab[i].has_exp, e, 1'b0);
      end

      // random words, mostly legal selectors
      for (int n = 0; n < RAND_WORDS; n++) begin
         w.func = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
         w.operand_a = rand_operand();
         w.operand_b = rand_operand();
         // bursts without gaps in some stretches
         send_word(w, 1'b0, e, (n % 100 < 30));
      end
      start <= 1'b0;

      while (alu_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("PASS checked_integer_alu_unit");
      end else begin
         $display("FAIL checked_integer_alu_unit");
      end
      $finish;
   end

endmodule
`default_nettype wire
